// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the gate router.
// Defining SYNTH removes every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MTR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MTR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MTR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/mtr_pkg.sv
// Package of the gate router: widths, codes, exp tables and shared types.
// Used by the interfaces, the exp unit, the divider and the top level.
`default_nettype none
package mtr_pkg;
  localparam int MAX_EXPERTS = 64;
  localparam int MAX_SELECT  = 8;
  localparam int IDX_W   = $clog2(MAX_EXPERTS);
  localparam int CNT_W   = $clog2(MAX_EXPERTS) + 1;
  localparam int SEL_W   = $clog2(MAX_SELECT);
  localparam int KCNT_W  = 4;
  localparam int LOGIT_W = 16;
  localparam int SCORE_W = 17;
  localparam int WT_W    = 24;
  localparam int DVD_W   = 33;
  localparam int DVR_W   = 24;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPERT_COUNT = 3'd0,
    CFG_SELECT_COUNT = 3'd1,
    CFG_GATE_MODE    = 3'd2,
    CFG_NORMALIZE    = 3'd3,
    CFG_ROUTE_SCALE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GATE_SOFTMAX     = 2'd0,
    GATE_SIGMOID     = 2'd1,
    GATE_SEL_SOFTMAX = 2'd2,
    GATE_INVALID     = 2'd3
  } gate_mode_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SCORE_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SCORE_W-1:0] exp_int_f(input logic [3:0] idx);
    logic [SCORE_W-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [SCORE_W-1:0] exp_mid_f(input logic [3:0] idx);
    logic [SCORE_W-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  function automatic logic [SCORE_W-1:0] exp_low_f(input logic [3:0] idx);
    logic [SCORE_W-1:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62780;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/mtr_if.sv
// Valid/ready channel interfaces of the gate router: logit beats in, route beats out.
// Depends on mtr_pkg for the field widths.
`default_nettype none
interface mtr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mtr_pkg::LOGIT_W-1:0]   logit;
  modport source (output valid, output logit, input ready);
  modport sink (input valid, input logit, output ready);
endinterface

interface mtr_out_if;
  logic                            valid;
  logic                            ready;
  logic [mtr_pkg::IDX_W-1:0]       expert_id;
  logic [mtr_pkg::WT_W-1:0]        weight;
  logic                            last_of_row;
  logic                            error;
  modport source (output valid, output expert_id, output weight, output last_of_row,
                  output error, input ready);
  modport sink (input valid, input expert_id, input weight, input last_of_row,
                input error, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mtr_exp.sv
// Two-stage exp(-m) unit for a Q8.8 magnitude, giving a Q1.16 result.
// Depends on mtr_pkg for the lookup tables.
`default_nettype none
module mtr_exp (
  input  wire logic                         clk,
  input  wire logic [15:0]                  arg,
  output logic      [mtr_pkg::SCORE_W-1:0]  result
);
  import mtr_pkg::*;

  logic [32:0]        prod1;
  logic [SCORE_W-1:0] r1;
  logic [3:0]         low_idx;
  logic               zero1;
  logic [32:0]        prod2;

  assign prod1 = 33'(exp_int_f(arg[11:8])) * 33'(exp_mid_f(arg[7:4])) + 33'd32768;
  assign prod2 = 33'(r1) * 33'(exp_low_f(low_idx)) + 33'd32768;

  always_ff @(posedge clk) begin
    r1      <= prod1[32:16];
    low_idx <= arg[3:0];
    zero1   <= (arg[15:8] >= 8'd12);
    result  <= zero1 ? '0 : prod2[32:16];
  end
endmodule
`default_nettype wire

// File: rtl/core/mtr_div.sv
// Restoring divider, one quotient bit per cycle, shared by all weight divisions.
// Depends on mtr_pkg for widths and the request and response structs.
`default_nettype none
module mtr_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mtr_pkg::div_req_t  req,
  output mtr_pkg::div_rsp_t       rsp
);
  import mtr_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0]  steps;
  logic               busy;
  logic               done;
  logic [DVD_W-1:0]   dvd;
  logic [DVR_W-1:0]   dvr;
  logic [DVR_W-1:0]   rem;
  logic [SCORE_W-1:0] quo;
  logic [DVR_W:0]     trial;
  logic               fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
        dvd   <= req.dividend;
        dvr   <= req.divisor;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        dvd   <= {dvd[DVD_W-2:0], 1'b0};
        rem   <= fits ? DVR_W'(trial - {1'b0, dvr}) : trial[DVR_W-1:0];
        quo   <= {quo[SCORE_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;
endmodule
`default_nettype wire

// File: rtl/core/moe_topk_gate_router_top.sv
// Top level of the mixture-of-experts top-k gate router.
// Depends on mtr_pkg, mtr_if, mtr_exp, mtr_div and assert_macros.svh.
//
// Usage: logit_ch carries one signed Q8.8 logit per beat, experts in index order.
// Logits load at one beat per cycle while ready is high. After the last logit of
// a row the block drops ready and runs the gate: for softmax and sigmoid, passes
// over the score memory through one shared exp unit and one shared bit-serial
// divider; then k top-k scans over the row's experts. Renormalization adds one
// division per selected expert; the divider dominates.
// route_ch then gives k beats (expert_id, weight, last_of_row), best first,
// or one error beat. A stalled receiver holds the current beat and the block;
// no logit is taken until the last beat of the row is delivered.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle: the
// user must keep to this, as the block itself does not enforce it.
// Synchronous reset restores the register defaults and empties the row;
// the score memory needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module moe_topk_gate_router_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  mtr_in_if.sink                                logit_ch,
  mtr_out_if.source                             route_ch,
  input  wire logic                             cfg_we,
  input  wire logic [mtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mtr_pkg::CFG_W-1:0]        cfg_data
);
  import mtr_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK, S_ERR,
    S_A_RD, S_A_EXP0, S_A_EXP1, S_A_EXP2,
    S_B_RD, S_B_DIV, S_B_WAIT,
    S_G_RD, S_G_EXP0, S_G_EXP1, S_G_EXP2, S_G_WAIT,
    S_T_RD, S_T_CMP,
    S_W_RD, S_W_GET, S_W_EXP1, S_W_EXP2,
    S_D_DIV, S_D_WAIT, S_N_SUM, S_N_DIV, S_N_WAIT,
    S_SCALE, S_EMIT
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     expert_count;
  logic [KCNT_W-1:0]    select_count;
  gate_mode_t           gate_mode;
  logic                 normalize_enable;
  logic [15:0]          route_scale;

  logic [CNT_W-1:0]          load_index;
  logic signed [LOGIT_W-1:0] running_max;
  logic [WT_W-1:0]           running_sum;
  logic [CNT_W-1:0]          row_n;
  logic [KCNT_W-1:0]         row_k;
  logic [CNT_W-1:0]          idx;
  logic [KCNT_W-1:0]         sel;
  logic                      have;
  logic [IDX_W-1:0]          best_idx;
  logic [SCORE_W-1:0]        best_val;
  logic [MAX_EXPERTS-1:0]    used;
  logic [IDX_W-1:0]          selected_ids [MAX_SELECT];
  logic [WT_W-1:0]           selected_weights [MAX_SELECT];
  logic [SCORE_W-1:0]        top;
  logic                      neg;

  logic [SCORE_W-1:0] score_store [MAX_EXPERTS];
  logic [SCORE_W-1:0] rdata;
  logic [IDX_W-1:0]   raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   waddr;
  logic [SCORE_W-1:0] wdata;

  logic [15:0]        exp_arg;
  logic [SCORE_W-1:0] exp_out;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_beat;
  logic               out_beat;
  logic               load_bad;
  logic               row_end;
  logic               sel_bad;
  logic               take_now;
  logic [IDX_W-1:0]   new_best;
  logic [LOGIT_W-1:0] x_abs;
  logic [DVR_W-1:0]   norm_sum;
  logic [32:0]        scaled;
  logic [SEL_W-1:0]   sel_i;
  logic [IDX_W-1:0]   idx_i;
  logic               idx_last;
  logic               sel_last;

  mtr_exp u_exp (.clk(clk), .arg(exp_arg), .result(exp_out));
  mtr_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign sel_i    = sel[SEL_W-1:0];
  assign idx_i    = idx[IDX_W-1:0];
  assign idx_last = (idx + 1'b1) == row_n;
  assign sel_last = (sel + 1'b1) == row_k;

  assign logit_ch.ready = (state == S_LOAD);
  assign in_beat  = logit_ch.valid && logit_ch.ready;
  assign out_beat = route_ch.valid && route_ch.ready;

  assign load_bad = (expert_count == '0) || (expert_count > CNT_W'(MAX_EXPERTS))
                    || (load_index >= CNT_W'(MAX_EXPERTS));
  assign row_end  = (load_index + 1'b1) >= expert_count;
  assign sel_bad  = (select_count == '0) || (select_count > KCNT_W'(MAX_SELECT))
                    || (CNT_W'(select_count) > row_n) || (gate_mode == GATE_INVALID);

  assign take_now = !used[idx_i] && (!have ||
                    ((gate_mode == GATE_SEL_SOFTMAX) ? ($signed(rdata) > $signed(best_val))
                                                     : (rdata > best_val)));
  assign new_best = take_now ? idx_i : best_idx;
  assign x_abs    = rdata[LOGIT_W-1] ? LOGIT_W'(-rdata[LOGIT_W-1:0]) : rdata[LOGIT_W-1:0];
  assign norm_sum = (running_sum < DVR_W'(4)) ? DVR_W'(4) : running_sum;
  assign scaled   = 33'(selected_weights[sel_i][SCORE_W-1:0]) * 33'(route_scale);

  always_comb begin
    case (state)
      S_A_EXP0: exp_arg = LOGIT_W'(running_max - $signed(rdata[LOGIT_W-1:0]));
      S_G_EXP0: exp_arg = x_abs;
      S_W_GET:  exp_arg = (sel == '0) ? '0 : LOGIT_W'(top[LOGIT_W-1:0] - rdata[LOGIT_W-1:0]);
      default:  exp_arg = '0;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_B_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {rdata, 16'b0};
        div_req.divisor  = running_sum;
      end
      S_G_EXP2: begin
        div_req.start    = 1'b1;
        div_req.dividend = neg ? {exp_out, 16'b0} : DVD_W'(33'h1_0000_0000);
        div_req.divisor  = DVR_W'(exp_out) + DVR_W'(65536);
      end
      S_D_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {selected_weights[sel_i][SCORE_W-1:0], 16'b0};
        div_req.divisor  = running_sum;
      end
      S_N_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {selected_weights[sel_i][SCORE_W-1:0], 16'b0};
        div_req.divisor  = norm_sum;
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = idx_i;
    wdata  = div_rsp.quotient;
    raddr  = idx_i;
    case (state)
      S_LOAD: begin
        mem_we = in_beat && !load_bad;
        waddr  = load_index[IDX_W-1:0];
        wdata  = SCORE_W'(logit_ch.logit);
      end
      S_A_EXP2: begin
        mem_we = 1'b1;
        wdata  = exp_out;
      end
      S_B_WAIT, S_G_WAIT: mem_we = div_rsp.done;
      S_W_RD:  raddr = selected_ids[sel_i];
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_store[waddr] <= wdata;
    end
    rdata <= score_store[raddr];
  end

  assign route_ch.valid       = (state == S_EMIT) || (state == S_ERR);
  assign route_ch.error       = (state == S_ERR);
  assign route_ch.expert_id   = (state == S_ERR) ? '0 : selected_ids[sel_i];
  assign route_ch.weight      = (state == S_ERR) ? '0 : selected_weights[sel_i];
  assign route_ch.last_of_row = (state == S_ERR) || sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_LOAD;
      expert_count     <= CNT_W'(8);
      select_count     <= KCNT_W'(2);
      gate_mode        <= GATE_SOFTMAX;
      normalize_enable <= 1'b0;
      route_scale      <= 16'd256;
      load_index       <= '0;
      running_max      <= '0;
      running_sum      <= '0;
      idx              <= '0;
      sel              <= '0;
      have             <= 1'b0;
      used             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_EXPERT_COUNT: expert_count     <= cfg_data[CNT_W-1:0];
          CFG_SELECT_COUNT: select_count     <= cfg_data[KCNT_W-1:0];
          CFG_GATE_MODE:    gate_mode        <= gate_mode_t'(cfg_data[1:0]);
          CFG_NORMALIZE:    normalize_enable <= cfg_data[0];
          CFG_ROUTE_SCALE:  route_scale      <= cfg_data;
          default:          route_scale      <= route_scale;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (load_bad) begin
              state <= S_ERR;
            end else begin
              if (load_index == '0 || logit_ch.logit > running_max) begin
                running_max <= logit_ch.logit;
              end
              load_index <= load_index + 1'b1;
              if (row_end) begin
                row_n <= expert_count;
                state <= S_CHECK;
              end
            end
          end
        end
        S_CHECK: begin
          row_k       <= select_count;
          idx         <= '0;
          sel         <= '0;
          have        <= 1'b0;
          used        <= '0;
          running_sum <= '0;
          if (sel_bad) begin
            state <= S_ERR;
          end else begin
            case (gate_mode)
              GATE_SOFTMAX: state <= S_A_RD;
              GATE_SIGMOID: state <= S_G_RD;
              default:      state <= S_T_RD;
            endcase
          end
        end
        S_ERR: begin
          if (out_beat) begin
            load_index <= '0;
            state      <= S_LOAD;
          end
        end
        S_A_RD:   state <= S_A_EXP0;
        S_A_EXP0: state <= S_A_EXP1;
        S_A_EXP1: state <= S_A_EXP2;
        S_A_EXP2: begin
          running_sum <= running_sum + WT_W'(exp_out);
          idx         <= idx_last ? '0 : idx + 1'b1;
          state       <= idx_last ? S_B_RD : S_A_RD;
        end
        S_B_RD: state <= S_B_DIV;
        S_B_DIV: state <= S_B_WAIT;
        S_B_WAIT: begin
          if (div_rsp.done) begin
            idx   <= idx_last ? '0 : idx + 1'b1;
            state <= idx_last ? S_T_RD : S_B_RD;
          end
        end
        S_G_RD: state <= S_G_EXP0;
        S_G_EXP0: begin
          neg   <= rdata[LOGIT_W-1];
          state <= S_G_EXP1;
        end
        S_G_EXP1: state <= S_G_EXP2;
        S_G_EXP2: state <= S_G_WAIT;
        S_G_WAIT: begin
          if (div_rsp.done) begin
            idx   <= idx_last ? '0 : idx + 1'b1;
            state <= idx_last ? S_T_RD : S_G_RD;
          end
        end
        S_T_RD: state <= S_T_CMP;
        S_T_CMP: begin
          if (idx_last) begin
            selected_ids[sel_i] <= new_best;
            used[new_best]      <= 1'b1;
            idx                 <= '0;
            have                <= 1'b0;
            sel                 <= sel_last ? '0 : sel + 1'b1;
            running_sum         <= '0;
            state               <= sel_last ? S_W_RD : S_T_RD;
          end else begin
            if (take_now) begin
              best_idx <= idx_i;
              best_val <= rdata;
              have     <= 1'b1;
            end
            idx   <= idx + 1'b1;
            state <= S_T_RD;
          end
        end
        S_W_RD: state <= S_W_GET;
        S_W_GET: begin
          if (sel == '0) begin
            top <= rdata;
          end
          if (gate_mode == GATE_SEL_SOFTMAX) begin
            state <= S_W_EXP1;
          end else begin
            selected_weights[sel_i] <= WT_W'(rdata);
            sel <= sel_last ? '0 : sel + 1'b1;
            if (!sel_last) begin
              state <= S_W_RD;
            end else if (normalize_enable) begin
              state <= S_N_SUM;
            end else begin
              state <= (route_scale != '0) ? S_SCALE : S_EMIT;
            end
          end
        end
        S_W_EXP1: state <= S_W_EXP2;
        S_W_EXP2: begin
          selected_weights[sel_i] <= WT_W'(exp_out);
          running_sum <= running_sum + WT_W'(exp_out);
          sel   <= sel_last ? '0 : sel + 1'b1;
          state <= sel_last ? S_D_DIV : S_W_RD;
        end
        S_D_DIV: state <= S_D_WAIT;
        S_D_WAIT: begin
          if (div_rsp.done) begin
            selected_weights[sel_i] <= WT_W'(div_rsp.quotient);
            sel <= sel_last ? '0 : sel + 1'b1;
            if (!sel_last) begin
              state <= S_D_DIV;
            end else if (normalize_enable) begin
              running_sum <= '0;
              state       <= S_N_SUM;
            end else begin
              state <= (route_scale != '0) ? S_SCALE : S_EMIT;
            end
          end
        end
        S_N_SUM: begin
          running_sum <= running_sum + WT_W'(selected_weights[sel_i][SCORE_W-1:0]);
          sel   <= sel_last ? '0 : sel + 1'b1;
          state <= sel_last ? S_N_DIV : S_N_SUM;
        end
        S_N_DIV: state <= S_N_WAIT;
        S_N_WAIT: begin
          if (div_rsp.done) begin
            selected_weights[sel_i] <= WT_W'(div_rsp.quotient);
            sel <= sel_last ? '0 : sel + 1'b1;
            if (!sel_last) begin
              state <= S_N_DIV;
            end else begin
              state <= (route_scale != '0) ? S_SCALE : S_EMIT;
            end
          end
        end
        S_SCALE: begin
          selected_weights[sel_i] <= scaled[32] ? {WT_W{1'b1}} : scaled[31:8];
          sel   <= sel_last ? '0 : sel + 1'b1;
          state <= sel_last ? S_EMIT : S_SCALE;
        end
        S_EMIT: begin
          if (out_beat) begin
            if (sel_last) begin
              sel        <= '0;
              load_index <= '0;
              state      <= S_LOAD;
            end else begin
              sel <= sel + 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `MTR_ASSERT_IMP(a_no_overlap, clk, rst, logit_ch.ready, !route_ch.valid)
  `MTR_ASSERT_IMP(a_err_last, clk, rst, route_ch.valid && route_ch.error, route_ch.last_of_row)
  `MTR_ASSERT_NXT(a_row_done, clk, rst, out_beat && route_ch.last_of_row, logit_ch.ready)
  `MTR_ASSERT_IMP(a_div_idle, clk, rst, div_req.start, !div_rsp.busy)
endmodule
`default_nettype wire

// File: test/moe_topk_gate_router_checker.sv
// Checker of the gate router: snoops the register port and both channels, predicts each
// row's route beats and compares them with the beats the block delivers.
// Depends on mtr_pkg and the channel interfaces in mtr_if.
`default_nettype none
module moe_topk_gate_router_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mtr_in_if                                  logit_ch,
  mtr_out_if                                 route_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtr_pkg::CFG_W-1:0]     cfg_data,
  output int                                 fail_count,
  output int                                 pending_routes
);
  import mtr_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] expert_id;
    logic [WT_W-1:0]  weight;
    logic             last_of_row;
    logic             error;
  } route_t;

  localparam longint unsigned EXP_INT[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
                                             60, 22, 8, 3, 1};
  localparam longint unsigned EXP_MID[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                             45042, 42313, 39750, 37341, 35079, 32954,
                                             30957, 29081, 27319, 25664};
  localparam longint unsigned EXP_LOW[16] = '{65536, 65280, 65026, 64772, 64520, 64268,
                                             64018, 63768, 63520, 63272, 63025, 62780,
                                             62535, 62291, 62048, 61806};

  route_t       route_q[$];
  int unsigned  n_experts, k_select, scale;
  gate_mode_t   mode;
  logic         norm_on;
  longint       scores[MAX_EXPERTS];
  int unsigned  fill;
  longint       row_max;

  function automatic longint unsigned exp_q16(longint unsigned m);
    longint unsigned r;
    m = m & 64'hFFFF;
    if ((m >> 8) >= 12) return 0;
    r = EXP_INT[m >> 8];
    r = (r * EXP_MID[(m >> 4) & 15] + 32768) >> 16;
    r = (r * EXP_LOW[m & 15] + 32768) >> 16;
    return r;
  endfunction

  function automatic void push_error();
    route_t r;
    r.expert_id = '0;
    r.weight = '0;
    r.last_of_row = 1'b1;
    r.error = 1'b1;
    route_q.push_back(r);
    fill = 0;
  endfunction

  function automatic void route_row(int unsigned n);
    bit              taken[MAX_EXPERTS];
    int unsigned     ids[MAX_SELECT];
    longint unsigned w[MAX_SELECT];
    longint unsigned sum, e;
    int unsigned     best;
    bit              have;
    route_t          r;
    if (k_select == 0 || k_select > MAX_SELECT || k_select > n || mode == GATE_INVALID) begin
      push_error();
      return;
    end
    if (mode == GATE_SOFTMAX) begin
      sum = 0;
      for (int i = 0; i < n; i++) begin
        scores[i] = exp_q16(row_max - scores[i]);
        sum += scores[i];
      end
      sum = sum & 64'hFFFF_FFFF;
      if (sum == 0) begin
        push_error();
        return;
      end
      for (int i = 0; i < n; i++) scores[i] = (longint'(scores[i]) << 16) / sum;
    end else if (mode == GATE_SIGMOID) begin
      for (int i = 0; i < n; i++) begin
        if (scores[i] >= 0) begin
          e = exp_q16(scores[i]);
          scores[i] = (64'd1 << 32) / (65536 + e);
        end else begin
          e = exp_q16(-scores[i]);
          scores[i] = (e << 16) / (65536 + e);
        end
      end
    end
    for (int i = 0; i < MAX_EXPERTS; i++) taken[i] = 0;
    for (int c = 0; c < k_select; c++) begin
      best = 0;
      have = 0;
      for (int i = 0; i < n; i++) begin
        if (!taken[i] && (!have || scores[i] > scores[best])) begin
          best = i;
          have = 1;
        end
      end
      taken[best] = 1;
      ids[c] = best;
    end
    if (mode == GATE_SEL_SOFTMAX) begin
      sum = 0;
      for (int c = 0; c < k_select; c++) begin
        w[c] = exp_q16(scores[ids[0]] - scores[ids[c]]);
        sum += w[c];
      end
      if (sum == 0) begin
        push_error();
        return;
      end
      for (int c = 0; c < k_select; c++) w[c] = (w[c] << 16) / sum;
    end else begin
      for (int c = 0; c < k_select; c++) w[c] = scores[ids[c]];
    end
    if (norm_on) begin
      sum = 0;
      for (int c = 0; c < k_select; c++) sum += w[c];
      if (sum < 4) sum = 4;
      for (int c = 0; c < k_select; c++) w[c] = (w[c] << 16) / sum;
    end
    if (scale != 0) begin
      for (int c = 0; c < k_select; c++) w[c] = (w[c] * scale) >> 8;
    end
    for (int c = 0; c < k_select; c++) begin
      r.expert_id = ids[c];
      r.weight = (w[c] > 64'hFFFFFF) ? 24'hFFFFFF : w[c][WT_W-1:0];
      r.last_of_row = (c + 1 == k_select);
      r.error = 1'b0;
      route_q.push_back(r);
    end
    fill = 0;
  endfunction

  function automatic void take_logit(logic signed [LOGIT_W-1:0] x);
    if (n_experts == 0 || n_experts > MAX_EXPERTS || fill >= MAX_EXPERTS) begin
      push_error();
      return;
    end
    scores[fill] = x;
    if (fill == 0 || longint'(x) > row_max) row_max = x;
    fill++;
    if (fill >= n_experts) route_row(n_experts);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] route mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    route_t want;
    if (rst) begin
      n_experts = 8;
      k_select = 2;
      mode = GATE_SOFTMAX;
      norm_on = 0;
      scale = 256;
      fill = 0;
      row_max = 0;
      route_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_EXPERT_COUNT: n_experts = cfg_data & 16'h7F;
          CFG_SELECT_COUNT: k_select = cfg_data & 16'hF;
          CFG_GATE_MODE:    mode = gate_mode_t'(cfg_data[1:0]);
          CFG_NORMALIZE:    norm_on = cfg_data[0];
          CFG_ROUTE_SCALE:  scale = cfg_data;
          default: ;
        endcase
      end
      if (route_ch.valid && route_ch.ready) begin
        if (route_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat id=%0d weight=%0d",
                                    route_ch.expert_id, route_ch.weight));
        end else begin
          want = route_q.pop_front();
          if (route_ch.expert_id !== want.expert_id)
            report_mismatch($sformatf("expert_id %0d, want %0d", route_ch.expert_id,
                                      want.expert_id));
          if (route_ch.weight !== want.weight)
            report_mismatch($sformatf("weight %0d, want %0d (id %0d)", route_ch.weight,
                                      want.weight, want.expert_id));
          if (route_ch.last_of_row !== want.last_of_row)
            report_mismatch($sformatf("last_of_row %b, want %b", route_ch.last_of_row,
                                      want.last_of_row));
          if (route_ch.error !== want.error)
            report_mismatch($sformatf("error %b, want %b", route_ch.error, want.error));
        end
      end
      if (logit_ch.valid && logit_ch.ready) take_logit(logit_ch.logit);
    end
    pending_routes = route_q.size();
  end

  initial begin
    fail_count = 0;
    pending_routes = 0;
  end
endmodule
`default_nettype wire

// File: test/moe_topk_gate_router_top_tb.sv
// Testbench top of the gate router: clock, reset, register writes and logit beats,
// with random gaps and receiver stalls; the checker module judges every route beat.
// Depends on mtr_pkg, mtr_if, the block and moe_topk_gate_router_checker.
`default_nettype none
module moe_topk_gate_router_top_tb;
  import mtr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    fail_count;
  int                    pending_routes;
  int                    cycles;
  int                    logits_sent;
  int                    stall_left;
  bit                    gaps_on;
  int unsigned           n_cur;
  logic signed [15:0]    tie_value;

  mtr_in_if  logit_ch();
  mtr_out_if route_ch();

  moe_topk_gate_router_top uut (
    .clk(clk), .rst(rst), .logit_ch(logit_ch), .route_ch(route_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  moe_topk_gate_router_checker checker_i (
    .clk(clk), .rst(rst), .logit_ch(logit_ch), .route_ch(route_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_routes(pending_routes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stalls come in random bursts while gaps are on.
  always @(posedge clk) begin
    if (rst) begin
      route_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      route_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      route_ch.ready <= 1'b0;
    end else begin
      route_ch.ready <= 1'b1;
    end
  end

  task automatic cfg_write(cfg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_EXPERT_COUNT) n_cur = value & 32'h7F;
  endtask

  task automatic send_logit(logic signed [15:0] v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      logit_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    logit_ch.valid <= 1'b1;
    logit_ch.logit <= v;
    do @(posedge clk); while (!logit_ch.ready);
    logits_sent++;
  endtask

  task automatic wait_drained();
    logit_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_routes != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_logit();
    case ($urandom_range(0, 4))
      0: tie_value = $urandom;
      1: tie_value = $urandom_range(0, 1023) - 512;
      2: tie_value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: tie_value = $urandom_range(0, 3) == 0 ? tie_value : 16'($urandom);
    endcase
    return tie_value;
  endfunction

  task automatic send_row(int unsigned n);
    for (int i = 0; i < n; i++) send_logit(pick_logit());
  endtask

  task automatic set_all(int unsigned n, int unsigned k, gate_mode_t m, bit nrm,
                         int unsigned sc);
    cfg_write(CFG_EXPERT_COUNT, n);
    cfg_write(CFG_SELECT_COUNT, k);
    cfg_write(CFG_GATE_MODE, m);
    cfg_write(CFG_NORMALIZE, nrm);
    cfg_write(CFG_ROUTE_SCALE, sc);
  endtask

  initial begin
    int unsigned n, k, sc;
    gate_mode_t  m;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    logit_ch.valid = 1'b0;
    logit_ch.logit = '0;
    route_ch.ready = 1'b0;
    cycles = 0;
    logits_sent = 0;
    gaps_on = 1;
    n_cur = 8;
    tie_value = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, extremes and a tie between two maxima.
    send_logit(16'sh7FFF); send_logit(16'sh8000); send_logit(0); send_logit(-1);
    send_logit(1); send_logit(16'sh7FFF); send_logit(256); send_logit(-256);
    wait_drained();
    set_all(3, 3, GATE_SIGMOID, 1, 65535);
    send_logit(1000); send_logit(-1000); send_logit(0);
    wait_drained();
    set_all(3, 2, GATE_SEL_SOFTMAX, 0, 0);
    send_logit(16'sh8000); send_logit(16'sh8000); send_logit(5);
    wait_drained();
    cfg_write(CFG_GATE_MODE, GATE_INVALID);
    send_row(3);
    wait_drained();
    set_all(3, 4, GATE_SOFTMAX, 0, 256);
    send_row(3);
    wait_drained();
    cfg_write(CFG_EXPERT_COUNT, 0);
    send_logit(7);
    wait_drained();
    cfg_write(CFG_EXPERT_COUNT, 100);
    send_logit(-7);
    wait_drained();
    // Row length cut below the logits already loaded.
    set_all(8, 1, GATE_SOFTMAX, 1, 512);
    send_row(5);
    wait_drained();
    cfg_write(CFG_EXPERT_COUNT, 3);
    send_logit(300);
    wait_drained();

    while (logits_sent < 330) begin
      if (logits_sent > 280) gaps_on = 0;
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
        1:       n = 64;
        2, 3:    n = $urandom_range(9, 24);
        default: n = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0:       k = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
        1:       k = $urandom_range(1, 8);
        default: k = $urandom_range(1, (n >= 1 && n < 8) ? n : 8);
      endcase
      m = gate_mode_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
      case ($urandom_range(0, 4))
        0:       sc = 0;
        1:       sc = 65535;
        2:       sc = 256;
        default: sc = $urandom_range(0, 65535);
      endcase
      set_all(n, k, m, $urandom_range(0, 1), sc);
      repeat ($urandom_range(1, 3)) begin
        if (n_cur == 0 || n_cur > MAX_EXPERTS) send_row($urandom_range(1, 3));
        else send_row(n_cur);
      end
      wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
